// ===== design/htt_pkg.sv =====
// Shared types and constants of the hashed transposition table.
// Used by htt_ctrl, htt_dpath and hashed_transposition_table; no dependencies.
`default_nettype none

package htt_pkg;

  // Request kinds; the fourth code is dropped without touching the table
  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_STORE  = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  // Hash word and finalizer constants
  localparam int unsigned HASH_W     = 64;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned HASH_SHIFT = 33;
  localparam logic [HASH_W-1:0] HASH_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [HASH_W-1:0] HASH_MUL_B = 64'hc4ceb9fe1a85ec53;

  // Remainder unit: fold one hash byte a cycle, then two compare-and-subtract
  // stages a cycle; the step counter rests at MOD_LAST when done
  localparam int unsigned MOD_CNT_W  = 4;
  localparam int unsigned MOD_BITS   = 8;
  localparam int unsigned MOD_FOLDS  = HASH_W / MOD_BITS;
  localparam int unsigned MOD_REDUCE = 3;
  localparam int unsigned MOD_LAST   = MOD_FOLDS + MOD_REDUCE;

  // Partial-product step of one 64-bit multiply
  typedef enum logic [1:0] {
    STEP_LL  = 2'd0,
    STEP_LH  = 2'd1,
    STEP_HL  = 2'd2,
    STEP_FIN = 2'd3
  } mul_step_e;

  // Controller to datapath commands
  typedef struct packed {
    logic      load_in;
    logic      mul_en;
    mul_step_e mul_step;
    logic      mul_sel_b;
    logic      mod_start;
    logic      mod_step;
    logic      sweep_en;
    logic      mem_wr;
    logic      mem_rd;
    logic      load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       sweep_last;
    logic       mod_done;
    logic [1:0] kind;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/htt_ctrl.sv =====
// Controller of the hashed transposition table: request sequencing and
// output handshake. Depends on htt_pkg.
`default_nettype none

module htt_ctrl
  import htt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] kind_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire sts_t       sts_i,
  output cmd_t            cmd_o
);

  typedef enum logic [6:0] {
    ST_SWEEP  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_MUL_A  = 7'b0000100,
    ST_MUL_B  = 7'b0001000,
    ST_MOD    = 7'b0010000,
    ST_ACCESS = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_e;

  state_e    state_q, state_d;
  mul_step_e step_q, step_d;
  logic      out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep_en = 1'b1;
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          step_d        = STEP_LL;
          case (kind_e'(kind_i))
            KIND_LOOKUP: state_d = ST_MUL_A;
            KIND_STORE:  state_d = ST_MUL_A;
            KIND_CLEAR:  state_d = ST_SWEEP;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL_A, ST_MUL_B: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_step  = step_q;
        cmd_o.mul_sel_b = (state_q == ST_MUL_B);
        step_d          = mul_step_e'(step_q + 2'd1);
        if (step_q == STEP_FIN) begin
          if (state_q == ST_MUL_A) begin
            state_d = ST_MUL_B;
          end else begin
            cmd_o.mod_start = 1'b1;
            state_d         = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_done) state_d = ST_ACCESS;
      end
      ST_ACCESS: begin
        if (sts_i.kind == KIND_STORE) begin
          cmd_o.mem_wr = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d      = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_SWEEP;
      end
    endcase
  end

  // Hold a result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  // Start with a pass that empties the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      step_q      <= STEP_LL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/htt_dpath.sv =====
// Datapath of the hashed transposition table: hash multiplier, remainder
// unit, slot memories and result register. Depends on htt_pkg.
`default_nettype none

module htt_dpath
  import htt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [63:0] board_i,
  input  wire logic [7:0]  depth_i,
  input  wire logic [31:0] score_in_i,
  output logic             hit_o,
  output logic [31:0]      score_out_o
);

  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam bit          IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef struct packed {
    logic [63:0] key;
    logic [7:0]  depth;
    logic [31:0] score;
  } entry_t;

  // Request registers
  logic [1:0]        kind_q;
  logic [63:0]       board_q;
  logic [7:0]        depth_q;
  logic [31:0]       score_q;

  // Hash datapath
  logic [HASH_W-1:0] h_q, acc_q, prod_q;
  logic [HASH_W-1:0] mul_c, hash_sum, hash_mix;
  logic [HALF_W-1:0] mul_x, mul_y;
  logic [HASH_W-1:0] mul_p;

  logic [IDX_W-1:0]  idx;
  logic              mod_done;
  logic [IDX_W-1:0]  sweep_addr_q;

  entry_t            entry_mem [TABLE_ENTRIES];
  logic              valid_mem [TABLE_ENTRIES];
  entry_t            rd_entry_q;
  logic              rd_valid_q;

  logic              hit_q;
  logic [31:0]       score_out_q;
  logic              hit;

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      kind_q  <= kind_i;
      board_q <= board_i;
      depth_q <= depth_i;
      score_q <= score_in_i;
    end
  end

  // One 32x32 multiplier shared by the partial products
  assign mul_c    = cmd_i.mul_sel_b ? HASH_MUL_B : HASH_MUL_A;
  assign mul_x    = (cmd_i.mul_step == STEP_HL) ? h_q[HASH_W-1:HALF_W] : h_q[HALF_W-1:0];
  assign mul_y    = (cmd_i.mul_step == STEP_LH) ? mul_c[HASH_W-1:HALF_W] : mul_c[HALF_W-1:0];
  assign mul_p    = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};
  assign hash_sum = acc_q + prod_q;
  assign hash_mix = hash_sum ^ (hash_sum >> HASH_SHIFT);

  // Load the first xor-shift, accumulate low 64 bits of the product, then mix
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      h_q <= board_i ^ (board_i >> HASH_SHIFT);
    end else if (cmd_i.mul_en) begin
      case (cmd_i.mul_step)
        STEP_LL: begin
          prod_q <= mul_p;
        end
        STEP_LH: begin
          acc_q  <= prod_q;
          prod_q <= {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
        end
        STEP_HL: begin
          acc_q  <= hash_sum;
          prod_q <= {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
        end
        STEP_FIN: begin
          h_q <= hash_mix;
        end
        default: begin
          prod_q <= prod_q;
        end
      endcase
    end
  end

  // Slot index: low bits, or a folding remainder unit
  if (IS_POW2) begin : g_idx_mask
    assign idx      = h_q[IDX_W-1:0];
    assign mod_done = 1'b1;
  end else begin : g_idx_mod
    localparam int unsigned ACC_W = IDX_W + $clog2(HASH_W);
    localparam logic [ACC_W-1:0] MODULUS = ACC_W'(TABLE_ENTRIES);
    localparam logic [2:0] TOP_SHIFT = 3'(2 * MOD_REDUCE - 1);

    typedef logic [HASH_W-1:0][IDX_W-1:0] weight_tab_t;

    // Residue of each hash bit weight 2**i modulo the table size
    function automatic weight_tab_t weight_table();
      weight_tab_t     tab;
      longint unsigned w;
      w = 1;
      for (int unsigned i = 0; i < HASH_W; i++) begin
        tab[i] = IDX_W'(w);
        w = w << 1;
        if (w >= TABLE_ENTRIES) w = w - TABLE_ENTRIES;
      end
      return tab;
    endfunction

    localparam weight_tab_t WEIGHTS = weight_table();

    logic [MOD_CNT_W-1:0] cnt_q;
    logic [ACC_W-1:0]     acc_q;
    logic [ACC_W-1:0]     term [MOD_BITS];
    logic [ACC_W-1:0]     pair_sum [MOD_BITS/2];
    logic [ACC_W-1:0]     byte_sum;
    logic                 folding;
    logic [1:0]           red_step;
    logic [2:0]           red_shift;
    logic [ACC_W-1:0]     mult_hi, mult_lo, red_mid, red_next;

    // Replace each hash bit of the current byte by its residue and add them
    always_comb begin
      for (int unsigned j = 0; j < MOD_BITS; j++) begin
        term[j] = h_q[{cnt_q[2:0], 3'(j)}] ? ACC_W'(WEIGHTS[{cnt_q[2:0], 3'(j)}]) : '0;
      end
      for (int unsigned j = 0; j < MOD_BITS / 2; j++) begin
        pair_sum[j] = term[2*j] + term[2*j+1];
      end
      byte_sum = (pair_sum[0] + pair_sum[1]) + (pair_sum[2] + pair_sum[3]);
    end

    // The folded sum stays below 64 times the modulus; take off 32x .. 1x
    assign folding   = (cnt_q < MOD_CNT_W'(MOD_FOLDS));
    assign red_step  = 2'(cnt_q - MOD_CNT_W'(MOD_FOLDS));
    assign red_shift = TOP_SHIFT - {red_step, 1'b0};
    assign mult_hi   = MODULUS << red_shift;
    assign mult_lo   = mult_hi >> 1;
    assign red_mid   = (acc_q >= mult_hi) ? acc_q - mult_hi : acc_q;
    assign red_next  = (red_mid >= mult_lo) ? red_mid - mult_lo : red_mid;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q <= MOD_CNT_W'(MOD_LAST);
      end else if (cmd_i.mod_start) begin
        cnt_q <= '0;
      end else if (cmd_i.mod_step && !mod_done) begin
        cnt_q <= cnt_q + MOD_CNT_W'(1);
      end
    end

    // Fold a byte, or run two subtract stages
    always_ff @(posedge clk_i) begin
      if (cmd_i.mod_start) begin
        acc_q <= '0;
      end else if (cmd_i.mod_step && !mod_done) begin
        acc_q <= folding ? acc_q + byte_sum : red_next;
      end
    end

    assign idx      = acc_q[IDX_W-1:0];
    assign mod_done = (cnt_q == MOD_CNT_W'(MOD_LAST));
  end

  // Advance the clearing pass; back to zero after the last slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_addr_q <= '0;
    end else if (cmd_i.sweep_en) begin
      sweep_addr_q <= (sweep_addr_q == LAST_IDX) ? '0 : sweep_addr_q + IDX_W'(1);
    end
  end

  // Slot data memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      entry_mem[idx] <= '{key: board_q, depth: depth_q, score: score_q};
    end
    if (cmd_i.mem_rd) begin
      rd_entry_q <= entry_mem[idx];
    end
  end

  // Slot valid memory: cleared by the pass, set by a store
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_en) begin
      valid_mem[sweep_addr_q] <= 1'b0;
    end else if (cmd_i.mem_wr) begin
      valid_mem[idx] <= 1'b1;
    end
    if (cmd_i.mem_rd) begin
      rd_valid_q <= valid_mem[idx];
    end
  end

  // An empty slot reads as all zero
  always_comb begin
    entry_t e;
    e   = rd_valid_q ? rd_entry_q : '0;
    hit = (e.key == board_q) && (e.depth >= depth_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      hit_q       <= hit;
      score_out_q <= hit ? (rd_valid_q ? rd_entry_q.score : '0) : '0;
    end
  end

  assign hit_o       = hit_q;
  assign score_out_o = score_out_q;

  assign sts_o.sweep_last = (sweep_addr_q == LAST_IDX);
  assign sts_o.mod_done   = mod_done;
  assign sts_o.kind       = kind_q;

endmodule

`default_nettype wire

// ===== design/hashed_transposition_table.sv =====
// Top level of the hashed transposition table: controller plus datapath.
// Depends on htt_pkg, htt_ctrl and htt_dpath.
`default_nettype none

// Direct-mapped table of TABLE_ENTRIES slots keyed by a 64-bit board word,
// indexed by a 64-bit finalizer hash. kind 0 looks up and returns one
// result (hit, score); kind 1 stores; kind 2 empties the table; kind 3 is
// dropped. One request is worked at a time. Both 64-bit hash multiplies
// run on a single shared 32x32 multiplier. When TABLE_ENTRIES is a power
// of two the slot index is the low hash bits; otherwise it comes from a
// remainder unit that folds one hash byte a cycle and then reduces by
// compare-and-subtract. After reset and after each clear, a pass empties
// the slot valid memory, one slot per cycle, and no request is accepted
// then. A finished result sits in an output register, so the next request
// is accepted while it waits to be taken.
module hashed_transposition_table
  import htt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [63:0] board_i,
  input  wire logic [7:0]  depth_i,
  input  wire logic [31:0] score_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             hit_o,
  output logic [31:0]      score_out_o
);

  cmd_t cmd;
  sts_t sts;

  htt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  htt_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (kind_i),
    .board_i     (board_i),
    .depth_i     (depth_i),
    .score_in_i  (score_in_i),
    .hit_o       (hit_o),
    .score_out_o (score_out_o)
  );

`ifndef ASSERT_OFF
  // A request is taken only while no work is in flight
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !cmd.mul_en && !cmd.sweep_en && !cmd.mod_step)
    else $error("request accepted while busy");

  // A new result never overwrites one not yet taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("result overwritten before it was taken");

  // A loaded result is offered in the next cycle
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("loaded result not offered");

  // The clearing pass never overlaps a store, a read or an accepted request
  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sweep_en |-> !cmd.mem_wr && !cmd.mem_rd && !in_ready_o)
    else $error("memory access during clearing pass");
`endif

endmodule

`default_nettype wire
